>>> hw/rtl/hrht_pkg.sv
// Types, codes and character constants for the HTTP request head tokenizer.
`default_nettype none

package hrht_pkg;

  // Characters the tokenizer reacts to
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CTL_LO = 8'h09;
  localparam logic [7:0] CH_CTL_HI = 8'h0D;

  // Parse phase of the current request
  typedef enum logic [1:0] {
    PH_REQ_LINE = 2'd0,
    PH_HEADERS  = 2'd1,
    PH_DONE     = 2'd2,
    PH_REJECTED = 2'd3
  } phase_e;

  // Position inside a header line
  typedef enum logic [1:0] {
    HP_START = 2'd0,
    HP_NAME  = 2'd1,
    HP_BLANK = 2'd2,
    HP_VALUE = 2'd3
  } hpos_e;

  // Role of a content byte
  typedef enum logic [2:0] {
    ROLE_NONE    = 3'd0,
    ROLE_METHOD  = 3'd1,
    ROLE_PATH    = 3'd2,
    ROLE_VERSION = 3'd3,
    ROLE_HNAME   = 3'd4,
    ROLE_HVALUE  = 3'd5
  } role_e;

  // Line and request events
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_REQ_OK    = 3'd1,
    EV_HDR_COMMIT = 3'd2,
    EV_HDR_DROP  = 3'd3,
    EV_HDR_END   = 3'd4,
    EV_REJECT    = 3'd5,
    EV_COMPLETE  = 3'd6
  } ev_e;

  localparam logic [1:0] TOK_MAX = 2'd3;

  // Input request payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_request;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] role;
    logic [2:0] event_res;
    logic       last_of_run;
  } out_res_t;

  // Tokenizer state carried from byte to byte
  typedef struct packed {
    phase_e     phase;
    logic [1:0] tok_cnt;
    logic       in_tok;
    hpos_e      hpos;
    logic       held_cr;
  } tok_state_t;

  // State update plus an optional result
  typedef struct packed {
    tok_state_t st;
    logic       vld;
    out_res_t   res;
  } step_t;

endpackage

`default_nettype wire

>>> hw/rtl/http_request_head_tokenizer.sv
// Top level of the HTTP request head tokenizer: input register, classifier, result queue.
`default_nettype none

// Streaming tokenizer for an HTTP/1.1 request head. Each accepted request
// carries one raw byte; the block tags content bytes as method, path, version,
// header name or header value and reports line outcomes and the end of the
// request as event results. A byte passes from the input register through the
// classifier into a two-entry result queue whose head drives the output. The
// results of a byte load only once the queue is empty or its last is taken.
// Bytes that cause zero or one result are taken one per cycle while the
// consumer takes each result; a byte that causes two results (a line closed by
// the end mark, or a held CR followed by content) fills the result queue, and
// the next byte waits in the input register until the second of them is taken.
// The consumer builds the header store from the tagged bytes and events.
module http_request_head_tokenizer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hrht_pkg::in_req_t  in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hrht_pkg::out_res_t      out_res_o
);

  // Input register
  logic                 in_vld_q;
  hrht_pkg::in_req_t    in_q;

  // Tokenizer state
  hrht_pkg::tok_state_t st_q, st_d;

  // Result queue
  logic [1:0]           cnt_q, cnt_d;
  hrht_pkg::out_res_t   res0_q, res0_d, res1_q, res1_d;

  // Results of the byte in the input register
  hrht_pkg::out_res_t   r0, r1;
  logic [1:0]           ncnt;

  logic proc_fire;
  logic pop;

  // Build an event result
  function automatic hrht_pkg::out_res_t ev_res(hrht_pkg::ev_e e);
    hrht_pkg::out_res_t r;
    r           = '0;
    r.event_res = e;
    return r;
  endfunction

  // Role of a request-line token by its number
  function automatic hrht_pkg::role_e tok_role(logic [1:0] n);
    hrht_pkg::role_e r;
    case (n)
      2'd1:    r = hrht_pkg::ROLE_METHOD;
      2'd2:    r = hrht_pkg::ROLE_PATH;
      2'd3:    r = hrht_pkg::ROLE_VERSION;
      default: r = hrht_pkg::ROLE_NONE;
    endcase
    return r;
  endfunction

  // Classify one content byte
  function automatic hrht_pkg::step_t do_content(hrht_pkg::tok_state_t s, logic [7:0] c);
    hrht_pkg::step_t r;
    logic            blank;
    r        = '0;
    r.st     = s;
    r.res.out_byte = c;
    blank    = c inside {hrht_pkg::CH_SP, [hrht_pkg::CH_CTL_LO:hrht_pkg::CH_CTL_HI]};
    case (s.phase)
      hrht_pkg::PH_REQ_LINE: begin
        if (blank) begin
          r.st.in_tok = 1'b0;
        end else if (s.in_tok) begin
          r.vld      = 1'b1;
          r.res.role = tok_role(s.tok_cnt);
        end else if (s.tok_cnt != hrht_pkg::TOK_MAX) begin
          r.st.tok_cnt = s.tok_cnt + 2'd1;
          r.st.in_tok  = 1'b1;
          r.vld        = 1'b1;
          r.res.role   = tok_role(s.tok_cnt + 2'd1);
        end
      end
      hrht_pkg::PH_HEADERS: begin
        case (s.hpos)
          hrht_pkg::HP_START, hrht_pkg::HP_NAME: begin
            if (c == hrht_pkg::CH_COLON) begin
              r.st.hpos = hrht_pkg::HP_BLANK;
            end else begin
              r.st.hpos  = hrht_pkg::HP_NAME;
              r.vld      = 1'b1;
              r.res.role = hrht_pkg::ROLE_HNAME;
            end
          end
          hrht_pkg::HP_BLANK: begin
            if (c != hrht_pkg::CH_SP && c != hrht_pkg::CH_HT) begin
              r.st.hpos  = hrht_pkg::HP_VALUE;
              r.vld      = 1'b1;
              r.res.role = hrht_pkg::ROLE_HVALUE;
            end
          end
          default: begin
            r.vld      = 1'b1;
            r.res.role = hrht_pkg::ROLE_HVALUE;
          end
        endcase
      end
      default: ;
    endcase
    if (!r.vld) begin
      r.res = '0;
    end
    return r;
  endfunction

  // Close a line on CRLF
  function automatic hrht_pkg::step_t do_line_end(hrht_pkg::tok_state_t s);
    hrht_pkg::step_t r;
    r     = '0;
    r.st  = s;
    r.vld = 1'b1;
    if (s.phase == hrht_pkg::PH_REQ_LINE) begin
      if (s.tok_cnt == hrht_pkg::TOK_MAX) begin
        r.res      = ev_res(hrht_pkg::EV_REQ_OK);
        r.st.phase = hrht_pkg::PH_HEADERS;
      end else begin
        r.res      = ev_res(hrht_pkg::EV_REJECT);
        r.st.phase = hrht_pkg::PH_REJECTED;
      end
      r.st.tok_cnt = 2'd0;
      r.st.in_tok  = 1'b0;
    end else if (s.hpos == hrht_pkg::HP_START) begin
      r.res      = ev_res(hrht_pkg::EV_HDR_END);
      r.st.phase = hrht_pkg::PH_DONE;
    end else if (s.hpos == hrht_pkg::HP_NAME) begin
      r.res = ev_res(hrht_pkg::EV_HDR_DROP);
    end else begin
      r.res = ev_res(hrht_pkg::EV_HDR_COMMIT);
    end
    r.st.hpos = hrht_pkg::HP_START;
    return r;
  endfunction

  // Classify the registered byte
  always_comb begin
    hrht_pkg::step_t s1, s2;
    logic [7:0]      c;
    logic            line_done;
    c         = in_q.in_byte;
    st_d      = st_q;
    r0        = '0;
    r1        = '0;
    ncnt      = 2'd0;
    line_done = 1'b0;
    s1        = '0;
    s2        = '0;
    if (in_q.end_of_request) begin
      if (st_q.phase == hrht_pkg::PH_REQ_LINE || st_q.phase == hrht_pkg::PH_HEADERS) begin
        if (st_q.held_cr && c == hrht_pkg::CH_LF) begin
          s1   = do_line_end(st_q);
          r0   = s1.res;
          ncnt = 2'd1;
          if (s1.st.phase == hrht_pkg::PH_HEADERS || s1.st.phase == hrht_pkg::PH_DONE) begin
            r1   = ev_res(hrht_pkg::EV_COMPLETE);
            ncnt = 2'd2;
          end
        end else if (st_q.phase == hrht_pkg::PH_REQ_LINE) begin
          r0   = ev_res(hrht_pkg::EV_REJECT);
          ncnt = 2'd1;
        end else begin
          r0   = ev_res(hrht_pkg::EV_HDR_DROP);
          r1   = ev_res(hrht_pkg::EV_COMPLETE);
          ncnt = 2'd2;
        end
      end else if (st_q.phase == hrht_pkg::PH_DONE) begin
        r0   = ev_res(hrht_pkg::EV_COMPLETE);
        ncnt = 2'd1;
      end
      // Return to the reset state for the next request
      st_d = '{phase: hrht_pkg::PH_REQ_LINE, tok_cnt: 2'd0, in_tok: 1'b0,
               hpos: hrht_pkg::HP_START, held_cr: 1'b0};
    end else if (st_q.phase == hrht_pkg::PH_REQ_LINE ||
                 st_q.phase == hrht_pkg::PH_HEADERS) begin
      // Resolve a held CR first
      if (st_q.held_cr) begin
        st_d.held_cr = 1'b0;
        if (c == hrht_pkg::CH_LF) begin
          s1        = do_line_end(st_d);
          st_d      = s1.st;
          r0        = s1.res;
          ncnt      = 2'd1;
          line_done = 1'b1;
        end else begin
          s1   = do_content(st_d, hrht_pkg::CH_CR);
          st_d = s1.st;
          if (s1.vld) begin
            r0   = s1.res;
            ncnt = 2'd1;
          end
        end
      end
      // Then the byte itself
      if (!line_done) begin
        if (c == hrht_pkg::CH_CR) begin
          st_d.held_cr = 1'b1;
        end else begin
          s2   = do_content(st_d, c);
          st_d = s2.st;
          if (s2.vld) begin
            if (ncnt == 2'd0) begin
              r0 = s2.res;
            end else begin
              r1 = s2.res;
            end
            ncnt = ncnt + 2'd1;
          end
        end
      end
    end
    // Flag the final result of this byte
    if (ncnt == 2'd1) begin
      r0.last_of_run = 1'b1;
    end else if (ncnt == 2'd2) begin
      r1.last_of_run = 1'b1;
    end
  end

  // Handshakes: process when the queue will be empty after this cycle's pop
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = res0_q;
  assign pop         = out_valid_o && out_ready_i;
  assign proc_fire   = in_vld_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i));
  assign in_ready_o  = !in_vld_q || proc_fire;

  // Load or drain the result queue
  always_comb begin
    cnt_d  = cnt_q;
    res0_d = res0_q;
    res1_d = res1_q;
    if (proc_fire) begin
      cnt_d  = ncnt;
      res0_d = r0;
      res1_d = r1;
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      res0_d = res1_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      st_q     <= '{phase: hrht_pkg::PH_REQ_LINE, tok_cnt: 2'd0, in_tok: 1'b0,
                    hpos: hrht_pkg::HP_START, held_cr: 1'b0};
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (proc_fire) begin
        in_vld_q <= 1'b0;
      end
      cnt_q <= cnt_d;
      if (proc_fire) begin
        st_q <= st_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

`ifndef ASSERT_OFF
  // Queue never holds more than two results
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overflow");

  // A lone queued result is always the last of its byte
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q == 2'd1) |-> out_res_o.last_of_run)
    else $error("single queued result lacks last_of_run");

  // A result carries content or an event, never both
  a_role_xor_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.role != hrht_pkg::ROLE_NONE) |->
      (out_res_o.event_res == hrht_pkg::EV_NONE))
    else $error("result carries both role and event");

  // A held CR only exists while lines are still parsed
  a_held_cr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.held_cr |-> (st_q.phase == hrht_pkg::PH_REQ_LINE ||
                      st_q.phase == hrht_pkg::PH_HEADERS))
    else $error("held CR outside line parsing");

  // Being inside a token implies a token was started
  a_tok_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.in_tok |-> (st_q.tok_cnt != 2'd0))
    else $error("inside token with zero token count");
`endif

endmodule

`default_nettype wire
